// ===== hdl/epr_pkg.sv =====
package epr_pkg;

  localparam int CoordWidth  = 24;
  localparam int AngleWidth  = 16;
  localparam int CfgIdxWidth = 2;
  localparam int SeriesSteps = 7;

  // register indexes of the configuration port
  localparam logic [CfgIdxWidth-1:0] CfgAngleX = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgAngleY = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgAngleZ = 2'd2;

  localparam logic [AngleWidth-1:0] QuarterTurn = 16'd16384;
  localparam logic [31:0]           PiQ30       = 32'd3373259426;
  localparam logic [30:0]           Q30One      = 31'h40000000;

  typedef struct packed {
    logic signed [CoordWidth-1:0] point_x;
    logic signed [CoordWidth-1:0] point_y;
    logic signed [CoordWidth-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] rotated_x;
    logic signed [CoordWidth-1:0] rotated_y;
    logic signed [CoordWidth-1:0] rotated_z;
    logic                         clipped;
  } result_t;

  typedef struct packed {
    logic                  start;
    logic [AngleWidth-1:0] angle;
  } sine_req_t;

  // divisors of the nested sine series, innermost term first
  function automatic logic [7:0] series_div(input logic [2:0] step);
    logic [7:0] d;
    case (step)
      3'd0:    d = 8'd210;
      3'd1:    d = 8'd156;
      3'd2:    d = 8'd110;
      3'd3:    d = 8'd72;
      3'd4:    d = 8'd42;
      3'd5:    d = 8'd20;
      3'd6:    d = 8'd6;
      default: d = 8'd6;
    endcase
    return d;
  endfunction

  // floor(2^34 / divisor), quotient estimate is exact or one low
  function automatic logic [31:0] series_recip(input logic [2:0] step);
    logic [31:0] m;
    case (step)
      3'd0:    m = 32'd81808900;
      3'd1:    m = 32'd110127366;
      3'd2:    m = 32'd156180628;
      3'd3:    m = 32'd238609294;
      3'd4:    m = 32'd409044504;
      3'd5:    m = 32'd858993459;
      3'd6:    m = 32'd2863311530;
      default: m = 32'd2863311530;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/epr_sine_unit.sv =====
module epr_sine_unit
  import epr_pkg::*;
#(
  parameter int FRACTION_BITS = 14
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sine_req_t                    req_i,
  output logic                         done_o,
  output logic signed [FRACTION_BITS+1:0] value_o
);

  localparam int SW = FRACTION_BITS + 2;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_X    = 4'd1;
  localparam logic [3:0] ST_XS   = 4'd2;
  localparam logic [3:0] ST_X2   = 4'd3;
  localparam logic [3:0] ST_X2S  = 4'd4;
  localparam logic [3:0] ST_MT   = 4'd5;
  localparam logic [3:0] ST_DL   = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_DT   = 4'd8;
  localparam logic [3:0] ST_XT   = 4'd9;
  localparam logic [3:0] ST_FIN  = 4'd10;
  localparam logic [3:0] ST_DQ   = 4'd11;
  localparam logic [3:0] ST_DR   = 4'd12;

  logic [3:0]  state_q;
  logic [2:0]  step_q;
  logic        done_q;
  logic [14:0] r_q;
  logic        neg_q;
  logic [30:0] x_q;
  logic [31:0] x2_q;
  logic [30:0] t_q;
  logic [63:0] p_q;
  logic [31:0] n_q;
  logic [31:0] q_q;
  logic [8:0]  rem_q;
  logic signed [SW-1:0] value_q;

  logic [31:0] op_a, op_b;
  logic [63:0] prod;
  logic [7:0]  divisor;
  logic [31:0] qd;
  logic        corr;
  logic [31:0] v_round;
  logic [SW-1:0] mag;
  logic [14:0] r_fold;

  // shared multiplier, operands chosen by the sequencer
  always_comb begin
    case (state_q)
      ST_X: begin
        op_a = {17'd0, r_q};
        op_b = PiQ30;
      end
      ST_X2: begin
        op_a = {1'b0, x_q};
        op_b = {1'b0, x_q};
      end
      ST_MT: begin
        op_a = x2_q;
        op_b = {1'b0, t_q};
      end
      ST_DIV: begin
        op_a = n_q;
        op_b = series_recip(step_q);
      end
      ST_XT: begin
        op_a = {1'b0, x_q};
        op_b = {1'b0, t_q};
      end
      default: begin
        op_a = 32'd0;
        op_b = 32'd0;
      end
    endcase
  end

  assign prod = op_a * op_b;

  // reciprocal quotient estimate and its one-step correction
  assign divisor = series_div(step_q);
  assign qd      = q_q * {24'd0, divisor};
  assign corr    = (rem_q >= {1'b0, divisor});

  // quadrant fold of the request angle
  assign r_fold = req_i.angle[14] ? (15'd16384 - {1'b0, req_i.angle[13:0]})
                                  : {1'b0, req_i.angle[13:0]};

  // final rounding from q30 to the output fraction
  assign v_round = {1'b0, p_q[60:30]} + (32'd1 << (29 - FRACTION_BITS));
  assign mag     = SW'(v_round >> (30 - FRACTION_BITS));

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= 3'd0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: if (req_i.start) state_q <= ST_X;
        ST_X:    state_q <= ST_XS;
        ST_XS:   state_q <= ST_X2;
        ST_X2:   state_q <= ST_X2S;
        ST_X2S: begin
          step_q  <= 3'd0;
          state_q <= ST_MT;
        end
        ST_MT:   state_q <= ST_DL;
        ST_DL:   state_q <= ST_DIV;
        ST_DIV:  state_q <= ST_DQ;
        ST_DQ:   state_q <= ST_DR;
        ST_DR:   state_q <= ST_DT;
        ST_DT: begin
          if (step_q == 3'(SeriesSteps - 1)) begin
            state_q <= ST_XT;
          end else begin
            step_q  <= step_q + 3'd1;
            state_q <= ST_MT;
          end
        end
        ST_XT:   state_q <= ST_FIN;
        ST_FIN: begin
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        r_q   <= r_fold;
        neg_q <= req_i.angle[15];
      end
      ST_X, ST_X2, ST_MT, ST_DIV, ST_XT: p_q <= prod;
      ST_XS:  x_q <= 31'((p_q + 64'd16384) >> 15);
      ST_X2S: begin
        x2_q <= p_q[61:30];
        t_q  <= Q30One;
      end
      ST_DL:  n_q <= p_q[61:30];
      ST_DQ:  q_q <= {2'b00, p_q[63:34]};
      ST_DR:  rem_q <= 9'(n_q - qd);
      ST_DT:  t_q <= Q30One - 31'(q_q + {31'd0, corr});
      ST_FIN: value_q <= neg_q ? -$signed(mag) : $signed(mag);
      default: ;
    endcase
  end

  assign done_o  = done_q;
  assign value_o = value_q;

endmodule

// ===== hdl/epr_coef_unit.sv =====
module epr_coef_unit
  import epr_pkg::*;
#(
  parameter int FRACTION_BITS = 14
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [AngleWidth-1:0]                 angle_x_i,
  input  logic [AngleWidth-1:0]                 angle_y_i,
  input  logic [AngleWidth-1:0]                 angle_z_i,
  output logic                                  busy_o,
  output logic [8:0][FRACTION_BITS+2:0]         coef_o
);

  localparam int SW = FRACTION_BITS + 2;
  localparam int MW = FRACTION_BITS + 3;
  localparam logic signed [2*SW-1:0] Half = (2*SW)'(1) <<< (FRACTION_BITS - 1);
  localparam logic [MW-1:0] CoefOne =
    {{(MW-FRACTION_BITS-1){1'b0}}, 1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [8:0][MW-1:0] CoefIdentity =
    {CoefOne, {(3*MW){1'b0}}, CoefOne, {(3*MW){1'b0}}, CoefOne};

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_REQ  = 3'd1;
  localparam logic [2:0] C_WAIT = 3'd2;
  localparam logic [2:0] C_P1   = 3'd3;
  localparam logic [2:0] C_P2   = 3'd4;

  logic [2:0] state_q;
  logic [2:0] idx_q;
  logic       pend_q;
  logic [8:0][MW-1:0] coef_q;

  logic signed [SW-1:0] sin_q [6];
  logic signed [SW-1:0] sasb_q, casb_q, cbcg_q, casg_q, sasg_q;
  logic signed [SW-1:0] cbsg_q, cacg_q, sacg_q, sacb_q, cacb_q;

  sine_req_t            req;
  logic                 sine_done;
  logic signed [SW-1:0] sine_value;
  logic signed [SW-1:0] sa, ca, sb, cb, sg, cg;

  // product rounded half up back to the fraction width
  function automatic logic signed [SW-1:0] rmul(input logic signed [SW-1:0] a,
                                                 input logic signed [SW-1:0] b);
    logic signed [2*SW-1:0] p;
    p = a * b + Half;
    return SW'(p >>> FRACTION_BITS);
  endfunction

  // angle for the current sine, cosine as a quarter turn ahead
  always_comb begin
    req.start = (state_q == C_REQ);
    case (idx_q)
      3'd0:    req.angle = angle_x_i;
      3'd1:    req.angle = angle_x_i + QuarterTurn;
      3'd2:    req.angle = angle_y_i;
      3'd3:    req.angle = angle_y_i + QuarterTurn;
      3'd4:    req.angle = angle_z_i;
      3'd5:    req.angle = angle_z_i + QuarterTurn;
      default: req.angle = angle_x_i;
    endcase
  end

  epr_sine_unit #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_sine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .done_o (sine_done),
    .value_o(sine_value)
  );

  assign sa = sin_q[0];
  assign ca = sin_q[1];
  assign sb = sin_q[2];
  assign cb = sin_q[3];
  assign sg = sin_q[4];
  assign cg = sin_q[5];

  // angle write arriving mid-rebuild, served by a fresh pass afterwards
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (state_q == C_IDLE || state_q == C_P2) begin
      pend_q <= 1'b0;
    end else if (start_i) begin
      pend_q <= 1'b1;
    end
  end

  // sequencer and coefficient store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      idx_q   <= 3'd0;
      coef_q  <= CoefIdentity;
    end else begin
      case (state_q)
        C_IDLE: begin
          if (start_i) begin
            idx_q   <= 3'd0;
            state_q <= C_REQ;
          end
        end
        C_REQ:  state_q <= C_WAIT;
        C_WAIT: begin
          if (sine_done) begin
            if (idx_q == 3'd5) begin
              state_q <= C_P1;
            end else begin
              idx_q   <= idx_q + 3'd1;
              state_q <= C_REQ;
            end
          end
        end
        C_P1:   state_q <= C_P2;
        C_P2: begin
          coef_q[0] <= MW'(cbcg_q);
          coef_q[1] <= MW'(rmul(sasb_q, cg)) - MW'(casg_q);
          coef_q[2] <= MW'(rmul(casb_q, cg)) + MW'(sasg_q);
          coef_q[3] <= MW'(cbsg_q);
          coef_q[4] <= MW'(rmul(sasb_q, sg)) + MW'(cacg_q);
          coef_q[5] <= MW'(rmul(casb_q, sg)) - MW'(sacg_q);
          coef_q[6] <= -MW'(sb);
          coef_q[7] <= MW'(sacb_q);
          coef_q[8] <= MW'(cacb_q);
          if (start_i || pend_q) begin
            idx_q   <= 3'd0;
            state_q <= C_REQ;
          end else begin
            state_q <= C_IDLE;
          end
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  // sine capture and first rank of products
  always_ff @(posedge clk_i) begin
    if (state_q == C_WAIT && sine_done) sin_q[idx_q] <= sine_value;
    if (state_q == C_P1) begin
      sasb_q <= rmul(sa, sb);
      casb_q <= rmul(ca, sb);
      cbcg_q <= rmul(cb, cg);
      casg_q <= rmul(ca, sg);
      sasg_q <= rmul(sa, sg);
      cbsg_q <= rmul(cb, sg);
      cacg_q <= rmul(ca, cg);
      sacg_q <= rmul(sa, cg);
      sacb_q <= rmul(sa, cb);
      cacb_q <= rmul(ca, cb);
    end
  end

  assign busy_o = (state_q != C_IDLE);
  assign coef_o = coef_q;

endmodule

// ===== hdl/epr_datapath.sv =====
module epr_datapath
  import epr_pkg::*;
#(
  parameter int FRACTION_BITS = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [8:0][FRACTION_BITS+2:0] coef_i,
  input  logic                          in_valid_i,
  input  point_t                        in_data_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output result_t                       out_data_o
);

  localparam int MW   = FRACTION_BITS + 3;
  localparam int PW   = MW + CoordWidth;
  localparam int SUMW = PW + 2;
  localparam logic signed [SUMW-1:0] Half = SUMW'(1) <<< (FRACTION_BITS - 1);
  localparam logic signed [SUMW-1:0] MaxV =
    {{(SUMW-CoordWidth+1){1'b0}}, {(CoordWidth-1){1'b1}}};
  localparam logic signed [SUMW-1:0] MinV = ~MaxV;

  logic advance;
  logic v1_q, v2_q, v3_q;
  logic signed [CoordWidth-1:0] pt [3];
  logic signed [PW-1:0]   prod_q [3][3];
  logic signed [SUMW-1:0] sum_q [3];
  logic signed [SUMW-1:0] rnd [3];
  logic signed [CoordWidth-1:0] res [3];
  logic [2:0] clip;
  result_t out_q;

  // whole pipe moves unless the output holds a result not yet taken
  assign advance    = !v3_q || out_ready_i;
  assign in_ready_o = advance;

  assign pt[0] = in_data_i.point_x;
  assign pt[1] = in_data_i.point_y;
  assign pt[2] = in_data_i.point_z;

  // valid bits follow the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (advance) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // round, shift and saturate each row
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rnd[r] = (sum_q[r] + Half) >>> FRACTION_BITS;
      if (rnd[r] > MaxV) begin
        res[r]  = MaxV[CoordWidth-1:0];
        clip[r] = 1'b1;
      end else if (rnd[r] < MinV) begin
        res[r]  = MinV[CoordWidth-1:0];
        clip[r] = 1'b1;
      end else begin
        res[r]  = rnd[r][CoordWidth-1:0];
        clip[r] = 1'b0;
      end
    end
  end

  // stage one products, stage two row sums, stage three output register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= $signed(coef_i[r*3+c]) * pt[c];
        end
        sum_q[r] <= SUMW'(prod_q[r][0]) + SUMW'(prod_q[r][1]) + SUMW'(prod_q[r][2]);
      end
      out_q.rotated_x <= res[0];
      out_q.rotated_y <= res[1];
      out_q.rotated_z <= res[2];
      out_q.clipped   <= |clip;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/euler_point_rotator_core.sv =====
// pipeline: three register stages, products, row sums and output register
// throughput: one point per cycle, limited by the output handshake and by matrix rebuilds
// an angle write recomputes the matrix in a shared multiply sequencer, and a further write
// landing meanwhile starts another pass; no input transaction is taken then
// reset: asynchronous, clears angles to zero and loads the identity matrix
module euler_point_rotator_core
  import epr_pkg::*;
#(
  parameter int FRACTION_BITS = 14
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [AngleWidth-1:0]  cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  point_t                 in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output result_t                out_data_o
);

  logic [AngleWidth-1:0] angle_x_q, angle_y_q, angle_z_q;
  logic cfg_hit;
  logic coef_busy;
  logic dp_ready;
  logic [8:0][FRACTION_BITS+2:0] coef;

  assign cfg_hit = cfg_we_i && (cfg_index_i == CfgAngleX || cfg_index_i == CfgAngleY ||
                                cfg_index_i == CfgAngleZ);

  // angle registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_x_q <= '0;
      angle_y_q <= '0;
      angle_z_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgAngleX: angle_x_q <= cfg_wdata_i;
        CfgAngleY: angle_y_q <= cfg_wdata_i;
        CfgAngleZ: angle_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  epr_coef_unit #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_coef (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cfg_hit),
    .angle_x_i(angle_x_q),
    .angle_y_i(angle_y_q),
    .angle_z_i(angle_z_q),
    .busy_o   (coef_busy),
    .coef_o   (coef)
  );

  epr_datapath #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .coef_i     (coef),
    .in_valid_i (in_valid_i && !coef_busy),
    .in_data_i  (in_data_i),
    .in_ready_o (dp_ready),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  assign in_ready_o = dp_ready && !coef_busy;

`ifndef SYNTHESIS
  // no point enters while the matrix is being rebuilt
  assert property (@(posedge clk_i) disable iff (!rst_ni) coef_busy |-> !in_ready_o)
    else $error("input taken during coefficient update");

  // an angle write always starts a rebuild
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_hit |=> coef_busy)
    else $error("angle write did not start coefficient update");

  // input only taken when the pipe can move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!out_valid_o || out_ready_i))
    else $error("input ready while output stalled");
`endif

endmodule

// ===== sim/tb_euler_point_rotator_core.sv =====
module tb_euler_point_rotator_core;
  import epr_pkg::*;

  localparam int FracBits = 14;
  localparam longint CoordMax = (64'sd1 <<< (CoordWidth - 1)) - 1;
  localparam longint CoordMin = -CoordMax - 1;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_index_i = '0;
  logic [AngleWidth-1:0]  cfg_wdata_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  point_t                 in_data_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  result_t                out_data_o;

  // rotation matrix and angles as the block should hold them
  longint                 coef[9];
  logic [AngleWidth-1:0]  angle_reg[3];
  result_t                pending_rotations[$];
  int                     fail_count = 0;
  int                     send_idle_pct = 0;
  int                     recv_idle_pct = 0;

  euler_point_rotator_core #(.FRACTION_BITS(FracBits)) uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always #5 clk_i = ~clk_i;

  // sine of r quarter-turn units in Q30, nested series
  function automatic longint unsigned quarter_sine_q30(input longint unsigned r);
    longint unsigned x, x2, t;
    int unsigned divs[7] = '{210, 156, 110, 72, 42, 20, 6};
    x  = (r * 64'd3373259426 + 64'd16384) >> 15;
    x2 = (x * x) >> 30;
    t  = 64'd1 << 30;
    for (int i = 0; i < 7; i++) begin
      t = (64'd1 << 30) - ((x2 * t) >> 30) / divs[i];
    end
    return (x * t) >> 30;
  endfunction

  function automatic longint sine_q14(input logic [AngleWidth-1:0] a);
    longint unsigned r, v;
    longint s;
    r = a[13:0];
    if (a[14]) begin
      r = 64'd16384 - r;
    end
    v = quarter_sine_q30(r);
    s = longint'((v + (64'd1 << (29 - FracBits))) >> (30 - FracBits));
    return a[15] ? -s : s;
  endfunction

  function automatic longint round_mul(input longint a, input longint b);
    return (a * b + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
  endfunction

  function automatic void build_matrix();
    longint sa, ca, sb, cb, sg, cg;
    sa = sine_q14(angle_reg[0]);
    ca = sine_q14(angle_reg[0] + QuarterTurn);
    sb = sine_q14(angle_reg[1]);
    cb = sine_q14(angle_reg[1] + QuarterTurn);
    sg = sine_q14(angle_reg[2]);
    cg = sine_q14(angle_reg[2] + QuarterTurn);
    coef[0] = round_mul(cb, cg);
    coef[1] = round_mul(round_mul(sa, sb), cg) - round_mul(ca, sg);
    coef[2] = round_mul(round_mul(ca, sb), cg) + round_mul(sa, sg);
    coef[3] = round_mul(cb, sg);
    coef[4] = round_mul(round_mul(sa, sb), sg) + round_mul(ca, cg);
    coef[5] = round_mul(round_mul(ca, sb), sg) - round_mul(sa, cg);
    coef[6] = -sb;
    coef[7] = round_mul(sa, cb);
    coef[8] = round_mul(ca, cb);
  endfunction

  // matrix-vector product with rounding and saturation
  function automatic result_t rotate_point(input point_t p);
    result_t res;
    longint  c[3], acc, v;
    logic [CoordWidth-1:0] outv[3];
    res = '0;
    c[0] = p.point_x;
    c[1] = p.point_y;
    c[2] = p.point_z;
    for (int row = 0; row < 3; row++) begin
      acc = coef[row*3] * c[0] + coef[row*3+1] * c[1] + coef[row*3+2] * c[2];
      v = (acc + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
      if (v > CoordMax) begin
        v = CoordMax;
        res.clipped = 1'b1;
      end else if (v < CoordMin) begin
        v = CoordMin;
        res.clipped = 1'b1;
      end
      outv[row] = v[CoordWidth-1:0];
    end
    res.rotated_x = outv[0];
    res.rotated_y = outv[1];
    res.rotated_z = outv[2];
    return res;
  endfunction

  // receiver stalls
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // record expected rotation for each accepted input transaction
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      pending_rotations.push_back(rotate_point(in_data_i));
    end
  end

  // compare each output transaction with the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rotations.size() == 0) begin
        $display("%0t: result expected none actual %h", $time, out_data_o);
        fail_count++;
      end else begin
        want = pending_rotations.pop_front();
        if (out_data_o.rotated_x !== want.rotated_x) begin
          $display("%0t: rotated_x expected %0d actual %0d", $time,
                   want.rotated_x, out_data_o.rotated_x);
          fail_count++;
        end
        if (out_data_o.rotated_y !== want.rotated_y) begin
          $display("%0t: rotated_y expected %0d actual %0d", $time,
                   want.rotated_y, out_data_o.rotated_y);
          fail_count++;
        end
        if (out_data_o.rotated_z !== want.rotated_z) begin
          $display("%0t: rotated_z expected %0d actual %0d", $time,
                   want.rotated_z, out_data_o.rotated_z);
          fail_count++;
        end
        if (out_data_o.clipped !== want.clipped) begin
          $display("%0t: clipped expected %0b actual %0b", $time,
                   want.clipped, out_data_o.clipped);
          fail_count++;
        end
      end
    end
  end

  task automatic send_point(input point_t p);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_xyz(input longint x, input longint y, input longint z);
    point_t p;
    p.point_x = x[CoordWidth-1:0];
    p.point_y = y[CoordWidth-1:0];
    p.point_z = z[CoordWidth-1:0];
    send_point(p);
  endtask

  // let every expected result arrive, then the pipeline settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_rotations.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_angle(input logic [CfgIdxWidth-1:0] idx,
                             input logic [AngleWidth-1:0] val);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx != CfgAngleX && idx != CfgAngleY && idx != CfgAngleZ) begin
      return;
    end
    angle_reg[idx] = val;
    build_matrix();
  endtask

  task automatic set_angles(input logic [AngleWidth-1:0] ax,
                            input logic [AngleWidth-1:0] ay,
                            input logic [AngleWidth-1:0] az);
    write_angle(CfgAngleX, ax);
    write_angle(CfgAngleY, ay);
    write_angle(CfgAngleZ, az);
  endtask

  task automatic send_corner_points();
    send_xyz(0, 0, 0);
    send_xyz(CoordMax, CoordMax, CoordMax);
    send_xyz(CoordMin, CoordMin, CoordMin);
    send_xyz(CoordMax, CoordMin, 0);
    send_xyz(-1, 1, -8192);
    send_xyz(8191, -8193, 16384);
  endtask

  task automatic test_identity();
    send_corner_points();
  endtask

  task automatic test_directed_angles();
    // quarter turns, odd angles and an index outside the register list
    set_angles(QuarterTurn, 16'd32768, 16'd49152);
    send_corner_points();
    write_angle(2'd3, 16'hffff);
    send_xyz(12345, -54321, 777);
    // eighth turns push corner points past the range
    set_angles(16'd8192, 16'd8192, 16'd8192);
    send_corner_points();
    set_angles(16'hffff, 16'd1, 16'hffff);
    send_corner_points();
    drain_results();
  endtask

  task automatic test_random_points(input int count);
    point_t p;
    for (int i = 0; i < count; i++) begin
      p = point_t'(72'({$urandom, $urandom, $urandom}));
      if ($urandom_range(3) == 0) begin
        p.point_x = $signed(10'($urandom));
        p.point_y = $signed(10'($urandom));
      end
      send_point(p);
      if (i == count / 2) begin
        drain_results();
      end
    end
  endtask

  task automatic test_random_phase(input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    set_angles(16'($urandom), 16'($urandom), 16'($urandom));
    test_random_points(330);
    write_angle(2'($urandom_range(2)), 16'($urandom));
    test_random_points(330);
  endtask

  initial begin
    angle_reg[0] = '0;
    angle_reg[1] = '0;
    angle_reg[2] = '0;
    build_matrix();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_identity();
    test_directed_angles();
    test_random_phase(24, 75);
    test_random_phase(75, 24);
    test_random_phase(0, 0);
    drain_results();
    if (fail_count == 0) begin
      $display("tb_euler_point_rotator_core OK");
    end else begin
      $display("tb_euler_point_rotator_core NOT OK");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #5000000;
    $display("tb_euler_point_rotator_core NOT OK");
    $finish;
  end

endmodule
